/* hw/rtl/assert_macros.svh */
// Assertion macros for blocks that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/pts_pkg.sv */
package pts_pkg;

  localparam int PosW = 12;
  localparam int WidthRegW = 7;
  localparam int HeightRegW = 13;
  localparam int ChanW = 8;

  localparam logic [ChanW-1:0] INK_OFF = 8'd255;

  localparam logic [WidthRegW-1:0] WIDTH_RESET = 7'd64;
  localparam logic [HeightRegW-1:0] HEIGHT_RESET = 13'd4096;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic KIND_SEPARATOR = 1'b0;
  localparam logic KIND_CUT = 1'b1;

  typedef struct packed {
    logic [PosW-1:0] top;
    logic [PosW-1:0] bottom;
  } band_t;

  typedef enum logic {
    BK_SEP,
    BK_WALK
  } back_state_t;

endpackage

/* hw/rtl/pts_front.sv */
module pts_front #(
  parameter int MW = 64,
  parameter int MH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          q_full,
  input  logic [pts_pkg::ChanW-1:0]     red_level,
  input  logic [pts_pkg::ChanW-1:0]     green_level,
  input  logic [pts_pkg::ChanW-1:0]     blue_level,
  input  logic [pts_pkg::WidthRegW-1:0] width_reg,
  input  logic [pts_pkg::HeightRegW-1:0] height_reg,
  output logic                          push,
  output logic [MW-1:0]                 job_cut,
  output pts_pkg::band_t                job_band
);

  localparam int CW = (MW > 1) ? $clog2(MW) : 1;
  localparam int RW = (MH > 1) ? $clog2(MH) : 1;
  localparam int EW = (RW + 1 > pts_pkg::HeightRegW) ? RW + 1 : pts_pkg::HeightRegW;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          row_ink_r, row_ink_nxt;
  logic          band_open_r, band_open_nxt;
  logic [RW-1:0] band_start_r, band_start_nxt;
  logic [MW-1:0] bitmap_r, bitmap_nxt;

  logic                          accept;
  logic                          ink;
  logic                          row_ink;
  logic [MW-1:0]                 bitmap_set;
  logic [pts_pkg::WidthRegW-1:0] w_eff;
  logic [EW-1:0]                 h_eff;
  logic                          row_done;
  logic                          image_done;

  always_comb begin
    if (width_reg == '0) begin
      w_eff = pts_pkg::WidthRegW'(1);
    end else if (width_reg > pts_pkg::WidthRegW'(MW)) begin
      w_eff = pts_pkg::WidthRegW'(MW);
    end else begin
      w_eff = width_reg;
    end
    if (height_reg == '0) begin
      h_eff = EW'(1);
    end else if (EW'(height_reg) > EW'(MH)) begin
      h_eff = EW'(MH);
    end else begin
      h_eff = EW'(height_reg);
    end
  end

  assign accept = in_valid && !q_full;
  assign ink = (red_level != pts_pkg::INK_OFF) && (green_level != pts_pkg::INK_OFF) &&
               (blue_level != pts_pkg::INK_OFF);
  assign row_ink = row_ink_r || ink;
  assign bitmap_set = bitmap_r | ({{(MW-1){1'b0}}, ink} << col_r);
  assign row_done = (pts_pkg::WidthRegW'(col_r) + pts_pkg::WidthRegW'(1)) >= w_eff;
  assign image_done = (EW'(row_r) + EW'(1)) >= h_eff;

  always_comb begin
    job_cut = '0;
    for (int c = 0; c < MW - 1; c++) begin
      job_cut[c] = bitmap_set[c] && !bitmap_set[c+1] &&
                   (pts_pkg::WidthRegW'(c + 1) < w_eff);
    end
  end

  assign job_band.top = pts_pkg::PosW'(band_start_r);
  assign job_band.bottom = pts_pkg::PosW'(row_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    row_ink_nxt = row_ink_r;
    band_open_nxt = band_open_r;
    band_start_nxt = band_start_r;
    bitmap_nxt = bitmap_r;
    push = 1'b0;
    if (accept) begin
      if (!row_done) begin
        col_nxt = col_r + CW'(1);
        row_ink_nxt = row_ink;
        bitmap_nxt = bitmap_set;
      end else begin
        bitmap_nxt = bitmap_set;
        if (row_ink) begin
          band_open_nxt = 1'b1;
        end else if (band_open_r) begin
          push = 1'b1;
          bitmap_nxt = '0;
          band_open_nxt = 1'b0;
          band_start_nxt = row_r;
        end
        row_ink_nxt = 1'b0;
        col_nxt = '0;
        if (image_done) begin
          row_nxt = '0;
          bitmap_nxt = '0;
          band_open_nxt = 1'b0;
          band_start_nxt = '0;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      row_ink_r <= 1'b0;
      band_open_r <= 1'b0;
      band_start_r <= '0;
      bitmap_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      row_ink_r <= row_ink_nxt;
      band_open_r <= band_open_nxt;
      band_start_r <= band_start_nxt;
      bitmap_r <= bitmap_nxt;
    end
  end

endmodule

/* hw/rtl/pts_queue.sv */
module pts_queue #(
  parameter int DW = 88
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] head_data,
  output logic          not_empty,
  output logic          full
);

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign not_empty = count_r != 2'd0;
  assign full = count_r == 2'd2;
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* hw/rtl/pts_back.sv */
`include "assert_macros.svh"

module pts_back #(
  parameter int MW = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  logic [MW-1:0]             q_cut,
  input  pts_pkg::band_t            q_band,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_event_kind,
  output logic [pts_pkg::PosW-1:0]  out_position,
  output logic [pts_pkg::PosW-1:0]  out_band_top,
  output logic [pts_pkg::PosW-1:0]  out_band_bottom,
  output logic                      out_last
);

  localparam int CW = (MW > 1) ? $clog2(MW) : 1;

  pts_pkg::back_state_t state_r, state_nxt;
  logic [MW-1:0]             cut_sr_r, cut_sr_nxt;
  logic [CW-1:0]             col_r, col_nxt;
  logic                      valid_r, valid_nxt;
  logic                      kind_r, kind_nxt;
  logic [pts_pkg::PosW-1:0]  pos_r, pos_nxt;
  logic [pts_pkg::PosW-1:0]  top_r, top_nxt;
  logic [pts_pkg::PosW-1:0]  bottom_r, bottom_nxt;
  logic                      last_r, last_nxt;
  logic                      free;
  logic                      load;
  logic                      cut_last;

  assign free = !valid_r || !out_stall;
  assign cut_last = (cut_sr_r >> 1) == '0;

  always_comb begin
    state_nxt = state_r;
    cut_sr_nxt = cut_sr_r;
    col_nxt = col_r;
    kind_nxt = kind_r;
    pos_nxt = pos_r;
    top_nxt = top_r;
    bottom_nxt = bottom_r;
    last_nxt = last_r;
    load = 1'b0;
    q_pop = 1'b0;
    case (state_r)
      pts_pkg::BK_SEP: begin
        if (q_valid && free) begin
          load = 1'b1;
          kind_nxt = pts_pkg::KIND_SEPARATOR;
          pos_nxt = q_band.bottom;
          top_nxt = q_band.top;
          bottom_nxt = q_band.bottom;
          last_nxt = q_cut == '0;
          cut_sr_nxt = q_cut;
          col_nxt = '0;
          if (q_cut == '0) begin
            q_pop = 1'b1;
          end else begin
            state_nxt = pts_pkg::BK_WALK;
          end
        end
      end
      pts_pkg::BK_WALK: begin
        if (cut_sr_r[0]) begin
          if (free) begin
            load = 1'b1;
            kind_nxt = pts_pkg::KIND_CUT;
            pos_nxt = pts_pkg::PosW'(col_r);
            top_nxt = q_band.top;
            bottom_nxt = q_band.bottom;
            last_nxt = cut_last;
            cut_sr_nxt = cut_sr_r >> 1;
            col_nxt = col_r + CW'(1);
            if (cut_last) begin
              q_pop = 1'b1;
              state_nxt = pts_pkg::BK_SEP;
            end
          end
        end else begin
          cut_sr_nxt = cut_sr_r >> 1;
          col_nxt = col_r + CW'(1);
        end
      end
      default: begin
        state_nxt = pts_pkg::BK_SEP;
      end
    endcase
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pts_pkg::BK_SEP;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cut_sr_r <= cut_sr_nxt;
    col_r <= col_nxt;
    kind_r <= kind_nxt;
    pos_r <= pos_nxt;
    top_r <= top_nxt;
    bottom_r <= bottom_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_event_kind = kind_r;
  assign out_position = pos_r;
  assign out_band_top = top_r;
  assign out_band_bottom = bottom_r;
  assign out_last = last_r;

  `ASSERT_SAME(walk_has_job, clk, rst_n, state_r == pts_pkg::BK_WALK, q_valid)
  `ASSERT_SAME(walk_has_cut, clk, rst_n, state_r == pts_pkg::BK_WALK, cut_sr_r != '0)
  `ASSERT_SAME(pop_on_last, clk, rst_n, q_pop, load && last_nxt)
  `ASSERT_NEXT(pop_back_to_sep, clk, rst_n, q_pop, state_r == pts_pkg::BK_SEP && valid_r)

endmodule

/* hw/rtl/projection_text_segmenter_top.sv */
// Text segmenter by projection profiles.
// The input channel carries one RGB pixel per transaction in raster order; a
// pixel is ink when no channel equals 255. The output channel carries events:
// one separator event on the first blank row after a run of ink rows, then
// one cut event for the last ink column of each ink run that a blank column
// follows. Every event of a band carries the band's top and bottom rows, and
// the final event caused by a pixel has last set.
// The separator event for the pixel that closes a band passes through the
// queue and then the output register; the column walk that follows visits
// one column per cycle up to the last cut column, waiting at a cut column
// while the output is stalled. Two closed bands can wait in the queue, and
// input is stalled only while that queue is full. Width and height are set
// through the APB port; the user must write them only while the block is
// idle, which the block itself does not enforce. Reset clears the counters,
// the ink bitmap, the queue pointers and the output valid flag, and sets
// width 64 and height 4096. While the receiver stalls, the output holds and
// the walk waits at a cut column; pixels keep flowing until the queue fills.
module projection_text_segmenter_top #(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pts_pkg::ChanW-1:0]      in_red_level,
  input  logic [pts_pkg::ChanW-1:0]      in_green_level,
  input  logic [pts_pkg::ChanW-1:0]      in_blue_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_event_kind,
  output logic [pts_pkg::PosW-1:0]       out_position,
  output logic [pts_pkg::PosW-1:0]       out_band_top,
  output logic [pts_pkg::PosW-1:0]       out_band_bottom,
  output logic                           out_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int DW = MAX_WIDTH + $bits(pts_pkg::band_t);

  logic [pts_pkg::WidthRegW-1:0]  width_r, width_nxt;
  logic [pts_pkg::HeightRegW-1:0] height_r, height_nxt;
  logic                           wr_en;

  logic                  push;
  logic [MAX_WIDTH-1:0]  job_cut;
  pts_pkg::band_t        job_band;
  logic [DW-1:0]         head_data;
  logic                  q_valid;
  logic                  q_full;
  logic                  q_pop;
  logic [MAX_WIDTH-1:0]  head_cut;
  pts_pkg::band_t        head_band;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    width_nxt = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      if (paddr[2] == pts_pkg::REG_HEIGHT) begin
        height_nxt = pwdata[pts_pkg::HeightRegW-1:0];
      end else begin
        width_nxt = pwdata[pts_pkg::WidthRegW-1:0];
      end
    end
    if (paddr[2] == pts_pkg::REG_HEIGHT) begin
      prdata = 32'(height_r);
    end else begin
      prdata = 32'(width_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= pts_pkg::WIDTH_RESET;
      height_r <= pts_pkg::HEIGHT_RESET;
    end else begin
      width_r <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign in_stall = q_full;

  pts_front #(
    .MW(MAX_WIDTH),
    .MH(MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .q_full     (q_full),
    .red_level  (in_red_level),
    .green_level(in_green_level),
    .blue_level (in_blue_level),
    .width_reg  (width_r),
    .height_reg (height_r),
    .push       (push),
    .job_cut    (job_cut),
    .job_band   (job_band)
  );

  pts_queue #(
    .DW(DW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({job_cut, job_band}),
    .pop      (q_pop),
    .head_data(head_data),
    .not_empty(q_valid),
    .full     (q_full)
  );

  assign head_cut = head_data[DW-1:$bits(pts_pkg::band_t)];
  assign head_band = head_data[$bits(pts_pkg::band_t)-1:0];

  pts_back #(
    .MW(MAX_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cut          (head_cut),
    .q_band         (head_band),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_position   (out_position),
    .out_band_top   (out_band_top),
    .out_band_bottom(out_band_bottom),
    .out_last       (out_last)
  );

endmodule
